[rtl/sgrpm_pkg.sv]
// Shared types and constants for the stereo gain ramp and peak meter.
// Holds the control word layout, register codes and fixed-point widths.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package sgrpm_pkg;

  // Fixed-point gain format and field widths.
  localparam int GAIN_FRAC_BITS = 16;
  localparam int BLOCK_MAX      = 512;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_STEP_W     = 17;
  localparam int BLOCK_FRAMES_W = 10;
  localparam int TARGET_W       = 17;
  localparam int POS_W          = 32;
  localparam int LVL_W          = GAIN_FRAC_BITS + 1;
  localparam int SUM_W          = ((LVL_W > CFG_STEP_W) ? LVL_W : CFG_STEP_W) + 1;
  localparam int MUL_W          = (LVL_W > SAMPLE_W) ? LVL_W : SAMPLE_W;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int CNT_W          = $clog2(BLOCK_MAX + 1);

  localparam logic [LVL_W-1:0] LVL_UNITY = LVL_W'(1) << GAIN_FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_UNITY = SUM_W'(1) << GAIN_FRAC_BITS;

  // Configuration register indexes and reset values.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_GATE_STEP    = 2'd0;
  localparam logic [1:0] REG_VOLUME_STEP  = 2'd1;
  localparam logic [1:0] REG_BLOCK_FRAMES = 2'd2;
  localparam logic [CFG_STEP_W-1:0]     GATE_STEP_RST    = CFG_STEP_W'(273);
  localparam logic [CFG_STEP_W-1:0]     VOLUME_STEP_RST  = CFG_STEP_W'(2);
  localparam logic [BLOCK_FRAMES_W-1:0] BLOCK_FRAMES_RST = BLOCK_FRAMES_W'(512);

  // Gate direction codes.
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Multiplier operand pairs.
  localparam logic [1:0] MUL_GATE_VOL = 2'd0;
  localparam logic [1:0] MUL_P_P      = 2'd1;
  localparam logic [1:0] MUL_LEFT_Q   = 2'd2;
  localparam logic [1:0] MUL_RIGHT_Q  = 2'd3;

  // Jump conditions of the sequencer.
  localparam logic [2:0] C_NEXT     = 3'd0;
  localparam logic [2:0] C_JUMP     = 3'd1;
  localparam logic [2:0] C_IDLE     = 3'd2;
  localparam logic [2:0] C_DROP     = 3'd3;
  localparam logic [2:0] C_OUT_FULL = 3'd4;

  localparam int STEP_W = 4;

  // One microcode word: datapath enables plus the jump field.
  typedef struct packed {
    logic              gate_en;
    logic              pos_en;
    logic              vol_en;
    logic              peak_en;
    logic              block_en;
    logic              drop_en;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              q_en;
    logic              left_en;
    logic              right_en;
    logic              out_en;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Flags the datapath reports back to the sequencer.
  typedef struct packed {
    logic drop;
    logic out_full;
  } status_t;

endpackage

`default_nettype wire

[rtl/sgrpm_regs.sv]
// Configuration register file behind an APB-style port.
// Holds gate_step, volume_step and block_frames; depends on sgrpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgrpm_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sgrpm_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  output logic      [sgrpm_pkg::CFG_STEP_W-1:0]     gate_step,
  output logic      [sgrpm_pkg::CFG_STEP_W-1:0]     volume_step,
  output logic      [sgrpm_pkg::BLOCK_FRAMES_W-1:0] block_frames
);
  import sgrpm_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_step    <= GATE_STEP_RST;
      volume_step  <= VOLUME_STEP_RST;
      block_frames <= BLOCK_FRAMES_RST;
    end else if (wr) begin
      case (idx)
        REG_GATE_STEP:    gate_step    <= pwdata[CFG_STEP_W-1:0];
        REG_VOLUME_STEP:  volume_step  <= pwdata[CFG_STEP_W-1:0];
        REG_BLOCK_FRAMES: block_frames <= pwdata[BLOCK_FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    case (idx)
      REG_GATE_STEP:    prdata = 32'(gate_step);
      REG_VOLUME_STEP:  prdata = 32'(volume_step);
      REG_BLOCK_FRAMES: prdata = 32'(block_frames);
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sgrpm_seq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Drives the datapath through ctl_t words; depends on sgrpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgrpm_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  input  wire sgrpm_pkg::status_t status,
  output sgrpm_pkg::ctl_t        ctl,
  output logic                   busy
);
  import sgrpm_pkg::*;

  // Program step addresses.
  localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK  = 4'd1;
  localparam logic [STEP_W-1:0] S_GATE   = 4'd2;
  localparam logic [STEP_W-1:0] S_VOL    = 4'd3;
  localparam logic [STEP_W-1:0] S_GV     = 4'd4;
  localparam logic [STEP_W-1:0] S_PP     = 4'd5;
  localparam logic [STEP_W-1:0] S_Q      = 4'd6;
  localparam logic [STEP_W-1:0] S_LQ     = 4'd7;
  localparam logic [STEP_W-1:0] S_RQ     = 4'd8;
  localparam logic [STEP_W-1:0] S_RIGHT  = 4'd9;
  localparam logic [STEP_W-1:0] S_HOLD   = 4'd10;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd11;
  localparam logic [STEP_W-1:0] S_DROP   = 4'd12;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  // Control ROM: one word per step.
  function automatic ctl_t rom(input logic [STEP_W-1:0] s);
    ctl_t w;
    w = '0;
    case (s)
      S_WAIT: begin
        w.cond   = C_IDLE;
        w.target = S_WAIT;
      end
      S_CHECK: begin
        w.cond   = C_DROP;
        w.target = S_DROP;
      end
      S_GATE: begin
        w.gate_en = 1'b1;
        w.pos_en  = 1'b1;
      end
      S_VOL: begin
        w.vol_en  = 1'b1;
        w.peak_en = 1'b1;
      end
      S_GV: begin
        w.block_en = 1'b1;
        w.mul_en   = 1'b1;
        w.mul_sel  = MUL_GATE_VOL;
      end
      S_PP: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_P_P;
      end
      S_Q: begin
        w.q_en = 1'b1;
      end
      S_LQ: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_LEFT_Q;
      end
      S_RQ: begin
        w.left_en = 1'b1;
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_RIGHT_Q;
      end
      S_RIGHT: begin
        w.right_en = 1'b1;
      end
      S_HOLD: begin
        w.cond   = C_OUT_FULL;
        w.target = S_HOLD;
      end
      S_EMIT: begin
        w.out_en = 1'b1;
        w.cond   = C_JUMP;
        w.target = S_WAIT;
      end
      S_DROP: begin
        w.drop_en = 1'b1;
        w.cond    = C_JUMP;
        w.target  = S_WAIT;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

  assign ctl  = rom(step);
  assign busy = (step != S_WAIT);

  // Jump condition evaluation.
  always_comb begin
    case (ctl.cond)
      C_NEXT:     take = 1'b0;
      C_JUMP:     take = 1'b1;
      C_IDLE:     take = !frame_valid;
      C_DROP:     take = status.drop;
      C_OUT_FULL: take = status.out_full;
      default:    take = 1'b0;
    endcase
    step_next = take ? ctl.target : step + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sgrpm_dp.sv]
// Datapath: frame capture, gain ramps, peaks, block counter, shared
// multiplier and output word register. Depends on sgrpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgrpm_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire sgrpm_pkg::ctl_t                      ctl,
  input  wire logic                                 cap_en,
  input  wire logic signed [sgrpm_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic signed [sgrpm_pkg::SAMPLE_W-1:0] right_sample,
  input  wire logic [1:0]                           gate_direction,
  input  wire logic [sgrpm_pkg::TARGET_W-1:0]       volume_target,
  input  wire logic                                 volume_snap,
  input  wire logic                                 position_load,
  input  wire logic [sgrpm_pkg::POS_W-1:0]          position_value,
  input  wire logic [sgrpm_pkg::CFG_STEP_W-1:0]     gate_step,
  input  wire logic [sgrpm_pkg::CFG_STEP_W-1:0]     volume_step,
  input  wire logic [sgrpm_pkg::BLOCK_FRAMES_W-1:0] block_frames,
  input  wire logic                                 result_stall,
  output logic                                      result_valid,
  output logic signed [sgrpm_pkg::SAMPLE_W-1:0]     left_out,
  output logic signed [sgrpm_pkg::SAMPLE_W-1:0]     right_out,
  output logic [sgrpm_pkg::POS_W-1:0]               position,
  output logic                                      block_last,
  output logic [sgrpm_pkg::SAMPLE_W-1:0]            peak_left,
  output logic [sgrpm_pkg::SAMPLE_W-1:0]            peak_right,
  output sgrpm_pkg::status_t                        status
);
  import sgrpm_pkg::*;

  // Captured frame.
  logic signed [SAMPLE_W-1:0] in_left;
  logic signed [SAMPLE_W-1:0] in_right;
  logic [1:0]                 in_dir;
  logic [TARGET_W-1:0]        in_target;
  logic                       in_snap;
  logic                       in_load;
  logic [POS_W-1:0]           in_pos;

  // Persistent state.
  logic [LVL_W-1:0]    gate_level;
  logic [LVL_W-1:0]    volume_level;
  logic [SAMPLE_W-1:0] roll_left;
  logic [SAMPLE_W-1:0] roll_right;
  logic [SAMPLE_W-1:0] held_left;
  logic [SAMPLE_W-1:0] held_right;
  logic [CNT_W-1:0]    block_count;
  logic [POS_W-1:0]    frame_pos;

  // Work registers.
  logic [PROD_W-1:0]   prod;
  logic [LVL_W-1:0]    q;
  logic [SAMPLE_W-1:0] left_res;
  logic [SAMPLE_W-1:0] right_res;
  logic                last;

  logic [LVL_W-1:0]    gate_next;
  logic [LVL_W-1:0]    volume_next;
  logic [SUM_W-1:0]    g_sum;
  logic [SUM_W-1:0]    t_sat;
  logic [SUM_W-1:0]    v0;
  logic [SUM_W-1:0]    v_up;
  logic [SUM_W-1:0]    v_res;
  logic [SAMPLE_W-1:0] abs_left;
  logic [SAMPLE_W-1:0] abs_right;
  logic [CNT_W-1:0]    count_inc;
  logic [31:0]         limit;
  logic                block_end;
  logic [MUL_W-1:0]    op_a;
  logic [MUL_W-1:0]    op_b;
  logic [MUL_W-1:0]    prod_hi;
  logic [SAMPLE_W:0]   mag;
  logic [SAMPLE_W-1:0] signed_res;
  logic                res_neg;

  function automatic logic [SAMPLE_W-1:0] abs_s(input logic signed [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
  endfunction

  assign abs_left  = abs_s(in_left);
  assign abs_right = abs_s(in_right);

  assign status.drop     = (in_dir == DIR_DOWN) && (gate_level == '0);
  assign status.out_full = result_valid && result_stall;

  // Gate ramp with clamp to [0, unity].
  always_comb begin
    g_sum = SUM_W'(gate_level) + SUM_W'(gate_step);
    case (in_dir)
      DIR_UP:   gate_next = (g_sum > SUM_UNITY) ? LVL_UNITY : LVL_W'(g_sum);
      DIR_DOWN: gate_next = (SUM_W'(gate_level) > SUM_W'(gate_step))
                            ? LVL_W'(SUM_W'(gate_level) - SUM_W'(gate_step)) : '0;
      default:  gate_next = gate_level;
    endcase
  end

  // Volume ramp toward the saturated target, optionally snapped first.
  always_comb begin
    t_sat = (SUM_W'(in_target) > SUM_UNITY) ? SUM_UNITY : SUM_W'(in_target);
    v0    = in_snap ? t_sat : SUM_W'(volume_level);
    v_up  = v0 + SUM_W'(volume_step);
    if (t_sat > v0) begin
      v_res = (v_up > t_sat) ? t_sat : v_up;
    end else if (t_sat < v0) begin
      v_res = (v0 > t_sat + SUM_W'(volume_step)) ? v0 - SUM_W'(volume_step) : t_sat;
    end else begin
      v_res = v0;
    end
    volume_next = LVL_W'(v_res);
  end

  // Block length limit, clamped to [1, BLOCK_MAX].
  always_comb begin
    count_inc = block_count + 1'b1;
    if (block_frames == '0) begin
      limit = 32'd1;
    end else if (32'(block_frames) > 32'(BLOCK_MAX)) begin
      limit = 32'(BLOCK_MAX);
    end else begin
      limit = 32'(block_frames);
    end
    block_end = (32'(count_inc) >= limit);
  end

  // Multiplier operand selection.
  assign prod_hi = MUL_W'(prod[GAIN_FRAC_BITS +: MUL_W]);
  always_comb begin
    case (ctl.mul_sel)
      MUL_GATE_VOL: begin
        op_a = MUL_W'(gate_level);
        op_b = MUL_W'(volume_level);
      end
      MUL_P_P: begin
        op_a = prod_hi;
        op_b = prod_hi;
      end
      MUL_LEFT_Q: begin
        op_a = MUL_W'(abs_left);
        op_b = MUL_W'(q);
      end
      MUL_RIGHT_Q: begin
        op_a = MUL_W'(abs_right);
        op_b = MUL_W'(q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Scaled magnitude with the sign of the sample in flight.
  always_comb begin
    mag        = prod[GAIN_FRAC_BITS +: SAMPLE_W + 1];
    res_neg    = ctl.left_en ? in_left[SAMPLE_W-1] : in_right[SAMPLE_W-1];
    signed_res = res_neg ? SAMPLE_W'((SAMPLE_W + 1)'(0) - mag) : mag[SAMPLE_W-1:0];
  end

  // Frame capture and work registers.
  always_ff @(posedge clk) begin
    if (cap_en) begin
      in_left   <= left_sample;
      in_right  <= right_sample;
      in_dir    <= gate_direction;
      in_target <= volume_target;
      in_snap   <= volume_snap;
      in_load   <= position_load;
      in_pos    <= position_value;
    end
    if (ctl.mul_en) begin
      prod <= op_a * op_b;
    end
    if (ctl.q_en) begin
      q <= LVL_W'(prod_hi);
    end
    if (ctl.left_en) begin
      left_res <= signed_res;
    end
    if (ctl.right_en) begin
      right_res <= signed_res;
    end
    if (ctl.block_en) begin
      last <= block_end;
    end
  end

  // Gain levels, position, peaks and block counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_level   <= LVL_UNITY;
      volume_level <= LVL_UNITY;
      roll_left    <= '0;
      roll_right   <= '0;
      held_left    <= '0;
      held_right   <= '0;
      block_count  <= '0;
      frame_pos    <= '0;
    end else begin
      if (ctl.gate_en) begin
        gate_level <= gate_next;
      end
      if (ctl.pos_en) begin
        frame_pos <= (in_load ? in_pos : frame_pos) + 1'b1;
      end
      if (ctl.vol_en) begin
        volume_level <= volume_next;
      end
      if (ctl.peak_en) begin
        if (abs_left > roll_left) begin
          roll_left <= abs_left;
        end
        if (abs_right > roll_right) begin
          roll_right <= abs_right;
        end
      end
      if (ctl.block_en) begin
        if (block_end) begin
          held_left   <= roll_left;
          held_right  <= roll_right;
          roll_left   <= '0;
          roll_right  <= '0;
          block_count <= '0;
        end else begin
          block_count <= count_inc;
        end
      end
      // A dropped frame closes a partial block.
      if (ctl.drop_en && (block_count != '0)) begin
        held_left   <= roll_left;
        held_right  <= roll_right;
        roll_left   <= '0;
        roll_right  <= '0;
        block_count <= '0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out_en) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      left_out   <= left_res;
      right_out  <= right_res;
      position   <= frame_pos;
      block_last <= last;
      peak_left  <= held_left;
      peak_right <= held_right;
    end
  end

endmodule

`default_nettype wire

[rtl/stereo_gain_ramp_peak_meter.sv]
// Stereo gain ramp with peak meter: one 16-bit stereo frame per word.
// Each frame runs through the microcode program, which drives one shared
// 17x17 multiplier; a new frame is taken only once the previous one has been
// emitted or dropped.
// A result stalled downstream holds the program at its output step.
// Reset (synchronous) restores register defaults, unity gate and volume, zero peaks.
// Depends on sgrpm_pkg, sgrpm_regs, sgrpm_seq and sgrpm_dp.
`timescale 1ns / 1ps
`default_nettype none

module stereo_gain_ramp_peak_meter (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [sgrpm_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [31:0]                           pwdata,
  output logic      [31:0]                           prdata,
  output logic                                       pready,
  input  wire logic                                  frame_valid,
  output logic                                       frame_stall,
  input  wire logic signed [sgrpm_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic signed [sgrpm_pkg::SAMPLE_W-1:0] right_sample,
  input  wire logic [1:0]                            gate_direction,
  input  wire logic [sgrpm_pkg::TARGET_W-1:0]        volume_target,
  input  wire logic                                  volume_snap,
  input  wire logic                                  position_load,
  input  wire logic [sgrpm_pkg::POS_W-1:0]           position_value,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic signed [sgrpm_pkg::SAMPLE_W-1:0]      left_out,
  output logic signed [sgrpm_pkg::SAMPLE_W-1:0]      right_out,
  output logic [sgrpm_pkg::POS_W-1:0]                position,
  output logic                                       block_last,
  output logic [sgrpm_pkg::SAMPLE_W-1:0]             peak_left,
  output logic [sgrpm_pkg::SAMPLE_W-1:0]             peak_right
);
  import sgrpm_pkg::*;

  logic [CFG_STEP_W-1:0]     gate_step;
  logic [CFG_STEP_W-1:0]     volume_step;
  logic [BLOCK_FRAMES_W-1:0] block_frames;
  ctl_t                      ctl;
  status_t                   status;
  logic                      busy;
  logic                      cap_en;

  // A frame is taken only while the program sits at its wait step.
  assign frame_stall = busy;
  assign cap_en      = frame_valid && !busy;

  sgrpm_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .gate_step    (gate_step),
    .volume_step  (volume_step),
    .block_frames (block_frames)
  );

  sgrpm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .status      (status),
    .ctl         (ctl),
    .busy        (busy)
  );

  sgrpm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cap_en         (cap_en),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .gate_direction (gate_direction),
    .volume_target  (volume_target),
    .volume_snap    (volume_snap),
    .position_load  (position_load),
    .position_value (position_value),
    .gate_step      (gate_step),
    .volume_step    (volume_step),
    .block_frames   (block_frames),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .left_out       (left_out),
    .right_out      (right_out),
    .position       (position),
    .block_last     (block_last),
    .peak_left      (peak_left),
    .peak_right     (peak_right),
    .status         (status)
  );

endmodule

`default_nettype wire

[rtl/sgrpm_checker.sv]
// Port-level checker for the gain ramp block, bound to the top level.
// Depends on sgrpm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module sgrpm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           frame_valid,
  input wire logic                           frame_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic [sgrpm_pkg::SAMPLE_W-1:0] left_out,
  input wire logic [sgrpm_pkg::SAMPLE_W-1:0] right_out,
  input wire logic [sgrpm_pkg::POS_W-1:0]    position,
  input wire logic                           block_last
);

  // A stalled result word keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(left_out)
      && $stable(right_out) && $stable(position) && $stable(block_last))
    else $error("result word changed while stalled");

  // An accepted frame keeps the input stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("input not stalled after frame accepted");

  // A new result appears only as the frame's program finishes.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(frame_stall))
    else $error("result appeared with no frame in work");

  // A taken result is never shown twice.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("result repeated after acceptance");

endmodule

bind stereo_gain_ramp_peak_meter sgrpm_checker u_checker (.*);

`default_nettype wire
